// File: src/lcdc_pkg.sv
// Shared types and constants for the LCD controller register block.
`timescale 1ns / 1ps

package lcdc_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  reg_index;
    logic        word_access;
    logic [31:0] write_data;
    logic [31:0] desc_next;
    logic [31:0] desc_source;
    logic [31:0] desc_id;
    logic [31:0] desc_command;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        fetch_request;
    logic [31:0] fetch_address;
  } out_t;

  // item actions
  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_DESC   = 2'd3;

  // register map, word offsets
  localparam logic [7:0] REG_CTRL0       = 8'd0;
  localparam logic [7:0] REG_CTRL1       = 8'd1;
  localparam logic [7:0] REG_CTRL2       = 8'd2;
  localparam logic [7:0] REG_CTRL3       = 8'd3;
  localparam logic [7:0] REG_BRANCH0     = 8'd8;
  localparam logic [7:0] REG_BRANCH1     = 8'd9;
  localparam logic [7:0] REG_STATUS      = 8'd14;
  localparam logic [7:0] REG_MISC0       = 8'd15;
  localparam logic [7:0] REG_MISC1       = 8'd16;
  localparam logic [7:0] REG_MISC2       = 8'd17;
  localparam logic [7:0] REG_D0_NEXT     = 8'd128;
  localparam logic [7:0] REG_D0_SOURCE   = 8'd129;
  localparam logic [7:0] REG_D0_ID       = 8'd130;
  localparam logic [7:0] REG_D0_COMMAND  = 8'd131;
  localparam logic [7:0] REG_D1_NEXT     = 8'd132;
  localparam logic [7:0] REG_D1_SOURCE   = 8'd133;
  localparam logic [7:0] REG_D1_ID       = 8'd134;
  localparam logic [7:0] REG_D1_COMMAND  = 8'd135;

  // interrupt mask
  localparam logic [15:0] MASK_FIXED = 16'h7C8E;

  // control 0 bits that unmask interrupts
  localparam int CTRL_EN_BIT     = 0;
  localparam int CTRL_M_BIT21    = 21;
  localparam int CTRL_M_BIT20    = 20;
  localparam int CTRL_M_BIT10    = 10;
  localparam int CTRL_M_BIT6     = 6;
  localparam int CTRL_M_BIT5     = 5;
  localparam int CTRL_M_BIT4     = 4;

  localparam logic [15:0] MASK_FROM_B21 = 16'h0040;
  localparam logic [15:0] MASK_FROM_B20 = 16'h0200;
  localparam logic [15:0] MASK_FROM_B10 = 16'h0001;
  localparam logic [15:0] MASK_FROM_B6  = 16'h0080;
  localparam logic [15:0] MASK_FROM_B5  = 16'h0030;
  localparam logic [15:0] MASK_FROM_B4  = 16'h0002;

  // status bits
  localparam logic [15:0] ST_QUICK_DIS  = 16'h0080;
  localparam logic [15:0] ST_BRANCH     = 16'h0200;
  localparam logic [15:0] ST_START      = 16'h0002;
  localparam logic [15:0] ST_END        = 16'h0100;

  // descriptor command flags
  localparam int CMD_START_BIT = 22;
  localparam int CMD_END_BIT   = 21;

endpackage

// File: src/lcdc_core.sv
// Register file, interrupt logic and frame engine of the LCD controller.
`timescale 1ns / 1ps

module lcdc_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  lcdc_pkg::in_t   item,
  output lcdc_pkg::out_t  result
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_START = 2'd2,
    PH_END   = 2'd3
  } phase_t;

  logic [31:0] ctrl [4];
  logic [31:0] branch0;
  logic [31:0] branch1;
  logic [15:0] status;
  logic [31:0] misc [3];
  logic [31:0] d0 [4];
  logic [31:0] d1 [4];
  logic [15:0] mask;
  logic        toggled;
  phase_t      phase;

  logic [31:0] ctrl_next [4];
  logic [31:0] branch0_next;
  logic [31:0] branch1_next;
  logic [15:0] status_next;
  logic [31:0] misc_next [3];
  logic [31:0] d0_next [4];
  logic [31:0] d1_next [4];
  logic [15:0] mask_next;
  logic        toggled_next;
  phase_t      phase_next;

  logic [31:0] rd;
  logic        req;
  logic [31:0] addr;
  logic [31:0] wd;
  logic [15:0] m;

  always_comb begin
    ctrl_next    = ctrl;
    branch0_next = branch0;
    branch1_next = branch1;
    status_next  = status;
    misc_next    = misc;
    d0_next      = d0;
    d1_next      = d1;
    mask_next    = mask;
    toggled_next = toggled;
    phase_next   = phase;
    rd           = '0;
    req          = 1'b0;
    addr         = '0;
    wd           = item.write_data;
    m            = lcdc_pkg::MASK_FIXED;

    unique case (item.action)
      lcdc_pkg::ACT_READ: begin
        if (item.word_access) begin
          unique case (item.reg_index)
            lcdc_pkg::REG_CTRL0:      rd = ctrl[0];
            lcdc_pkg::REG_CTRL1:      rd = ctrl[1];
            lcdc_pkg::REG_CTRL2:      rd = ctrl[2];
            lcdc_pkg::REG_CTRL3:      rd = ctrl[3];
            lcdc_pkg::REG_BRANCH0:    rd = branch0;
            lcdc_pkg::REG_BRANCH1:    rd = branch1;
            lcdc_pkg::REG_STATUS:     rd = {16'h0000, status};
            lcdc_pkg::REG_MISC0:      rd = misc[0];
            lcdc_pkg::REG_MISC1:      rd = misc[1];
            lcdc_pkg::REG_MISC2:      rd = misc[2];
            lcdc_pkg::REG_D0_NEXT:    rd = d0[0];
            lcdc_pkg::REG_D0_SOURCE:  rd = d0[1];
            lcdc_pkg::REG_D0_ID:      rd = d0[2];
            lcdc_pkg::REG_D0_COMMAND: rd = d0[3];
            lcdc_pkg::REG_D1_NEXT:    rd = d1[0];
            lcdc_pkg::REG_D1_SOURCE:  rd = d1[1];
            lcdc_pkg::REG_D1_ID:      rd = d1[2];
            lcdc_pkg::REG_D1_COMMAND: rd = d1[3];
            default:                  rd = '0;
          endcase
        end
      end
      lcdc_pkg::ACT_WRITE: begin
        if (item.word_access) begin
          unique case (item.reg_index)
            lcdc_pkg::REG_CTRL0: begin
              if (ctrl[0][lcdc_pkg::CTRL_EN_BIT] != wd[lcdc_pkg::CTRL_EN_BIT]) begin
                toggled_next = 1'b1;
              end
              ctrl_next[0] = wd;
              if (wd[lcdc_pkg::CTRL_M_BIT21]) m = m | lcdc_pkg::MASK_FROM_B21;
              if (wd[lcdc_pkg::CTRL_M_BIT20]) m = m | lcdc_pkg::MASK_FROM_B20;
              if (wd[lcdc_pkg::CTRL_M_BIT10]) m = m | lcdc_pkg::MASK_FROM_B10;
              if (wd[lcdc_pkg::CTRL_M_BIT6])  m = m | lcdc_pkg::MASK_FROM_B6;
              if (wd[lcdc_pkg::CTRL_M_BIT5])  m = m | lcdc_pkg::MASK_FROM_B5;
              if (wd[lcdc_pkg::CTRL_M_BIT4])  m = m | lcdc_pkg::MASK_FROM_B4;
              mask_next = m;
            end
            lcdc_pkg::REG_CTRL1:   ctrl_next[1] = wd;
            lcdc_pkg::REG_CTRL2:   ctrl_next[2] = wd;
            lcdc_pkg::REG_CTRL3:   ctrl_next[3] = wd;
            lcdc_pkg::REG_BRANCH0: branch0_next = wd;
            lcdc_pkg::REG_BRANCH1: branch1_next = wd;
            // write one to clear
            lcdc_pkg::REG_STATUS:  status_next = status & ~wd[15:0];
            lcdc_pkg::REG_MISC0:   misc_next[0] = wd;
            lcdc_pkg::REG_MISC1:   misc_next[1] = wd;
            lcdc_pkg::REG_MISC2:   misc_next[2] = wd;
            lcdc_pkg::REG_D0_NEXT: d0_next[0] = wd;
            lcdc_pkg::REG_D1_NEXT: d1_next[0] = wd;
            default: ;
          endcase
        end
      end
      lcdc_pkg::ACT_TICK: begin
        if (toggled) begin
          if (!ctrl[0][lcdc_pkg::CTRL_EN_BIT]) begin
            status_next = status_next | lcdc_pkg::ST_QUICK_DIS;
            phase_next  = PH_IDLE;
          end
          toggled_next = 1'b0;
        end
        // when enabled the toggle path left the phase alone
        if (ctrl[0][lcdc_pkg::CTRL_EN_BIT]) begin
          unique case (phase)
            PH_IDLE: begin
              if (branch0[0]) begin
                branch0_next = {branch0[31:1], 1'b0};
                if (branch0[1]) status_next = status_next | lcdc_pkg::ST_BRANCH;
                addr = {branch0[31:4], 4'b0000};
              end else begin
                addr = d0[0];
              end
              req        = 1'b1;
              phase_next = PH_WAIT;
            end
            PH_WAIT: ;
            PH_START: begin
              if (d0[3][lcdc_pkg::CMD_START_BIT]) begin
                status_next = status_next | lcdc_pkg::ST_START;
              end
              phase_next = PH_END;
            end
            PH_END: begin
              if (d0[3][lcdc_pkg::CMD_END_BIT]) begin
                status_next = status_next | lcdc_pkg::ST_END;
              end
              phase_next = PH_IDLE;
            end
            default: ;
          endcase
        end
      end
      lcdc_pkg::ACT_DESC: begin
        if (phase == PH_WAIT) begin
          d0_next[0] = item.desc_next;
          d0_next[1] = item.desc_source;
          d0_next[2] = item.desc_id;
          d0_next[3] = item.desc_command;
          phase_next = PH_START;
        end
      end
      default: ;
    endcase

    result.read_data     = rd;
    // every change of status or mask refreshes the line, so it tracks them
    result.irq           = |(status_next & mask_next);
    result.fetch_request = req;
    result.fetch_address = addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        ctrl[i] <= '0;
        d0[i]   <= '0;
        d1[i]   <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        misc[i] <= '0;
      end
      branch0 <= '0;
      branch1 <= '0;
      status  <= '0;
      mask    <= lcdc_pkg::MASK_FIXED;
      toggled <= 1'b0;
      phase   <= PH_IDLE;
    end else if (fire) begin
      ctrl    <= ctrl_next;
      d0      <= d0_next;
      d1      <= d1_next;
      misc    <= misc_next;
      branch0 <= branch0_next;
      branch1 <= branch1_next;
      status  <= status_next;
      mask    <= mask_next;
      toggled <= toggled_next;
      phase   <= phase_next;
    end
  end

endmodule

// File: src/lcd_controller_registers_and_frames.sv
// Top level of the LCD controller register block: input and result registers.
// Item flow: the input register loads at the accepting edge, the result
// register when the item fires, which a low out_ready can delay. Throughput:
// one item per cycle while out_ready allows; the register update and result
// logic sit between the two registers and never stall on their own.
// Reset (rst, synchronous): both stages empty, all register-file registers zero, interrupt
// mask 0x7C8E, frame engine idle.
`timescale 1ns / 1ps

module lcd_controller_registers_and_frames (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lcdc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lcdc_pkg::out_t  out_data
);

  logic           s1_valid;
  lcdc_pkg::in_t  s1_data;
  logic           out_adv;
  logic           fire;
  lcdc_pkg::out_t core_result;

  assign out_adv  = !out_valid || out_ready;
  assign fire     = s1_valid && out_adv;
  assign in_ready = !s1_valid || out_adv;

  lcdc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_data),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (out_adv) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_data <= in_data;
    if (fire) out_data <= core_result;
  end

endmodule
